// ===== rtl/core/usc_pkg.sv =====
package usc_pkg;

  // Reciprocal for an exact divide by 60 of any 32-bit value: (x * M) >> 37.
  localparam logic [31:0] DIV60_M     = 32'h8888_8889;
  localparam int          DIV60_SH    = 37;
  // Divide by 3 of an 18-bit value: (x * M) >> 19 (divide by 24 = >> 3 first).
  localparam logic [17:0] DIV3_M      = 18'd174763;
  // Divide by 7 of a 17-bit value: (x * M) >> 20.
  localparam logic [17:0] DIV7_M      = 18'd149797;
  // Divide by 1461 of a 17-bit value below 75280: (x * M) >> 27.
  localparam logic [16:0] DIV1461_M   = 17'd91868;

  localparam logic [16:0] DAY_OFS_1900 = 17'd25568;
  localparam logic [10:0] DAYS_4Y      = 11'd1461;
  localparam logic [8:0]  FEB_29_DAY   = 9'd59;

  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
  } usc_tod_t;

  typedef struct packed {
    logic [2:0] weekday;
    logic [7:0] year;
    logic [8:0] yday;
  } usc_date_t;

  // First day of each year inside a four-year block (first year is leap).
  function automatic logic [10:0] year_start(input logic [1:0] yoff);
    logic [10:0] r;
    unique case (yoff)
      2'd0:    r = 11'd0;
      2'd1:    r = 11'd366;
      2'd2:    r = 11'd731;
      2'd3:    r = 11'd1096;
      default: r = 11'd0;
    endcase
    return r;
  endfunction

  // First day of each month in a 366-day year.
  function automatic logic [8:0] month_start(input logic [3:0] mon);
    logic [8:0] r;
    unique case (mon)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd60;
      4'd3:    r = 9'd91;
      4'd4:    r = 9'd121;
      4'd5:    r = 9'd152;
      4'd6:    r = 9'd182;
      4'd7:    r = 9'd213;
      4'd8:    r = 9'd244;
      4'd9:    r = 9'd274;
      4'd10:   r = 9'd305;
      4'd11:   r = 9'd335;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/unix_seconds_to_calendar_unit.sv =====
// Channel   Ports                                   Handshake
// -------   -------------------------------------   ------------------------------
// in        unix_seconds                            start & !busy at rising edge
// out       second, minute, hour, weekday,          done high for one cycle,
//           years_since_1900, day_of_year,          taken at the edge ending it
//           month_index, day_of_month
//
// Eleven register stages, one word accepted per clock; busy is always low.
// An accepted word shows done when its valid bit reaches vld[11], the last stage.
// The depth is set by the chain of constant divides (60, 60, 24, 7/1461),
// each a reciprocal multiply with a register behind it.
// rst (synchronous) clears only the stage valid bits; data is not reset.
// The receiver cannot stall, so the pipeline never holds.
module unix_seconds_to_calendar_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] unix_seconds,
  output logic        done,
  output logic [5:0]  second,
  output logic [5:0]  minute,
  output logic [4:0]  hour,
  output logic [2:0]  weekday,
  output logic [7:0]  years_since_1900,
  output logic [8:0]  day_of_year,
  output logic [3:0]  month_index,
  output logic [4:0]  day_of_month
);
  import usc_pkg::*;

  // stage valid bits, index = stage number
  logic [11:1] vld;

  // stage 1: input capture
  logic [31:0] t1;
  // stage 2: minutes total
  logic [26:0] q1_2;
  logic [5:0]  tlo2;
  // stage 3: hours total, seconds
  logic [20:0] q2_3;
  logic [5:0]  q1lo3;
  logic [5:0]  sec3;
  // stage 4: days since 1970, minutes
  logic [15:0] q3_4;
  logic [4:0]  q2lo4;
  logic [5:0]  sec4;
  logic [5:0]  min4;
  // stage 5 onward carry time of day
  usc_tod_t    tod5, tod6, tod7, tod8, tod9, tod10, tod11;
  logic [16:0] day5, day6;
  logic [14:0] q7_6;
  logic [5:0]  qb6;
  logic [2:0]  wday7, wday8;
  logic [10:0] dblk7, dblk8;
  logic [7:0]  base7, base8;
  logic [1:0]  yoff8;
  usc_date_t   date9, date10, date11;
  logic [8:0]  adj9, adj10;
  logic [3:0]  mon10, mon11;
  logic [4:0]  dom11;

  // combinational terms between stages
  logic [63:0] prod1, prod2;
  logic [36:0] prod3;
  logic [34:0] prod7;
  logic [33:0] prodb;
  logic [5:0]  sec_c, min_c;
  logic [4:0]  hour_c;
  logic [16:0] day_c;
  logic [16:0] blk_ofs;
  logic [10:0] dblk_c;
  logic [2:0]  wday_c;
  logic [1:0]  yoff_c;
  logic [8:0]  yday_c;
  logic [8:0]  adj_c;
  logic        skip_c;
  logic [3:0]  mon_c;
  logic [4:0]  dom_c;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[10:1], start};
    end
  end

  // seconds / 60
  assign prod1 = 64'(t1) * 64'(DIV60_M);
  // remainder below 60 fits in the low 6 bits of the difference
  assign sec_c = tlo2 - 6'(q1_2 * 27'd60);
  // minutes / 60
  assign prod2 = 64'(q1_2) * 64'(DIV60_M);
  assign min_c = q1lo3 - 6'(q2_3 * 21'd60);
  // hours / 24 = (hours >> 3) / 3
  assign prod3 = 37'(q2_3[20:3]) * 37'(DIV3_M);
  assign hour_c = q2lo4 - 5'(q3_4 * 16'd24);
  assign day_c  = 17'(q3_4) + DAY_OFS_1900;

  // days since 1900: weekday and four-year block
  assign prod7   = 35'(day5) * 35'(DIV7_M);
  assign prodb   = 34'(day5) * 34'(DIV1461_M);
  assign wday_c  = day6[2:0] - 3'(q7_6 * 15'd7);
  assign blk_ofs = 17'(qb6) * 17'(DAYS_4Y);
  assign dblk_c  = 11'(day6 - blk_ofs);

  // year within the block: first year 366 days, the rest 365
  always_comb begin
    priority if (dblk7 < 11'd366) begin
      yoff_c = 2'd0;
    end else if (dblk7 < 11'd731) begin
      yoff_c = 2'd1;
    end else if (dblk7 < 11'd1096) begin
      yoff_c = 2'd2;
    end else begin
      yoff_c = 2'd3;
    end
  end

  // day of year; non-leap years skip Feb 29 of the month table
  assign yday_c = 9'(dblk8 - year_start(yoff8));
  assign skip_c = (yoff8 != 2'd0) && (yday_c >= FEB_29_DAY);
  assign adj_c  = yday_c + 9'(skip_c);

  // month: count month starts at or below the adjusted day
  always_comb begin
    mon_c = 4'd0;
    for (int i = 1; i < 12; i++) begin
      mon_c = mon_c + 4'(adj9 >= month_start(4'(i)));
    end
  end

  assign dom_c = 5'(adj10 - month_start(mon10) + 9'd1);

  always_ff @(posedge clk) begin
    t1     <= unix_seconds;

    q1_2   <= prod1[63:DIV60_SH];
    tlo2   <= t1[5:0];

    q2_3   <= prod2[57:DIV60_SH];
    q1lo3  <= q1_2[5:0];
    sec3   <= sec_c;

    q3_4   <= prod3[34:19];
    q2lo4  <= q2_3[4:0];
    sec4   <= sec3;
    min4   <= min_c;

    tod5   <= '{second: sec4, minute: min4, hour: hour_c};
    day5   <= day_c;

    tod6   <= tod5;
    day6   <= day5;
    q7_6   <= prod7[34:20];
    qb6    <= prodb[32:27];

    tod7   <= tod6;
    wday7  <= wday_c;
    dblk7  <= dblk_c;
    base7  <= {qb6, 2'b00};

    tod8   <= tod7;
    wday8  <= wday7;
    dblk8  <= dblk7;
    base8  <= base7;
    yoff8  <= yoff_c;

    tod9   <= tod8;
    date9  <= '{weekday: wday8, year: base8 + 8'(yoff8), yday: yday_c};
    adj9   <= adj_c;

    tod10  <= tod9;
    date10 <= date9;
    adj10  <= adj9;
    mon10  <= mon_c;

    tod11  <= tod10;
    date11 <= date10;
    mon11  <= mon10;
    dom11  <= dom_c;
  end

  assign done             = vld[11];
  assign second           = tod11.second;
  assign minute           = tod11.minute;
  assign hour             = tod11.hour;
  assign weekday          = date11.weekday;
  assign years_since_1900 = date11.year;
  assign day_of_year      = date11.yday;
  assign month_index      = mon11;
  assign day_of_month     = dom11;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

// Calendar converter check: each accepted word gets its typed date or one from a local
// gmtime-style predictor (2100 counted as leap) and is queued; each done
// strobe is matched against the oldest queued date, field by field.
module tb;

  // Broken-down time at the widths of the result ports.
  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [2:0] weekday;
    logic [7:0] year;
    logic [8:0] yday;
    logic [3:0] month;
    logic [4:0] mday;
  } cal_date_t;

  // One row of the directed table; the date is only typed in where it is
  // obvious, the rest go through the predictor.
  typedef struct packed {
    logic [31:0] secs;
    logic        typed;
    cal_date_t   date;
  } dir_row_t;

  localparam int unsigned DAYS_1900_TO_1970 = 25568;
  localparam int unsigned DAYS_PER_4Y       = 1461;
  localparam int unsigned LAST_FEB_DAY      = 59;   // yday of 29 Feb in a leap year
  localparam int unsigned SECS_PER_DAY      = 86400;
  localparam int unsigned LAST_UNIX_DAY     = 49710;
  localparam int          NUM_DIR           = 21;
  localparam int          NUM_RANDOM        = 1530;
  localparam int          DRAIN_CYCLES      = 20;   // 11-stage pipe plus margin
  // Month lengths with a 29-day February, Jan at index 0.
  localparam logic [11:0][4:0] MONTH_DAYS =
    {5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd29, 5'd31};

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [31:0] unix_seconds;
  logic        done;
  logic [5:0]  second;
  logic [5:0]  minute;
  logic [4:0]  hour;
  logic [2:0]  weekday;
  logic [7:0]  years_since_1900;
  logic [8:0]  day_of_year;
  logic [3:0]  month_index;
  logic [4:0]  day_of_month;

  // Typed expectation riding along with the word being offered.
  logic        drive_typed;
  cal_date_t   drive_date;

  cal_date_t   pending_dates[$];
  int          mismatch_count;
  dir_row_t    dir_rows [NUM_DIR];

  unix_seconds_to_calendar_unit u_dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .unix_seconds     (unix_seconds),
    .done             (done),
    .second           (second),
    .minute           (minute),
    .hour             (hour),
    .weekday          (weekday),
    .years_since_1900 (years_since_1900),
    .day_of_year      (day_of_year),
    .month_index      (month_index),
    .day_of_month     (day_of_month)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Predictor: split off time of day, rebase days to 1900, peel off
  // four-year blocks, then walk the month table.
  function automatic cal_date_t to_calendar(input logic [31:0] secs);
    cal_date_t   d;
    int unsigned t;
    int unsigned days;
    int unsigned yr;
    int unsigned mon;
    t        = secs;
    d.second = 6'(t % 60);
    t        = t / 60;
    d.minute = 6'(t % 60);
    t        = t / 60;
    d.hour   = 5'(t % 24);
    t        = t / 24;
    days      = t + DAYS_1900_TO_1970;
    d.weekday = 3'(days % 7);
    yr        = (days / DAYS_PER_4Y) * 4;
    days      = days % DAYS_PER_4Y;
    // past the leading leap year of the block
    if (days > 365) begin
      yr   = yr + (days - 1) / 365;
      days = (days - 1) % 365;
    end
    d.year = 8'(yr);
    d.yday = 9'(days);
    // common year: skip the missing 29 Feb so the 366-day table fits
    if ((yr % 4) != 0 && days >= LAST_FEB_DAY)
      days = days + 1;
    mon = 0;
    while (mon < 11 && days >= MONTH_DAYS[mon]) begin
      days = days - MONTH_DAYS[mon];
      mon  = mon + 1;
    end
    d.month = 4'(mon);
    d.mday  = 5'(days + 1);
    return d;
  endfunction

  task automatic compare_date(input cal_date_t want, input cal_date_t got);
    if (got.second !== want.second) begin
      $error("second: expected %0d, got %0d", want.second, got.second);
      mismatch_count++;
    end
    if (got.minute !== want.minute) begin
      $error("minute: expected %0d, got %0d", want.minute, got.minute);
      mismatch_count++;
    end
    if (got.hour !== want.hour) begin
      $error("hour: expected %0d, got %0d", want.hour, got.hour);
      mismatch_count++;
    end
    if (got.weekday !== want.weekday) begin
      $error("weekday: expected %0d, got %0d", want.weekday, got.weekday);
      mismatch_count++;
    end
    if (got.year !== want.year) begin
      $error("years_since_1900: expected %0d, got %0d", want.year, got.year);
      mismatch_count++;
    end
    if (got.yday !== want.yday) begin
      $error("day_of_year: expected %0d, got %0d", want.yday, got.yday);
      mismatch_count++;
    end
    if (got.month !== want.month) begin
      $error("month_index: expected %0d, got %0d", want.month, got.month);
      mismatch_count++;
    end
    if (got.mday !== want.mday) begin
      $error("day_of_month: expected %0d, got %0d", want.mday, got.mday);
      mismatch_count++;
    end
  endtask

  // Scoreboard. Accepts are queued before the strobe is checked, all on the
  // rising edge; inputs only move on the falling edge, so nothing races.
  always @(posedge clk) begin : check_words
    cal_date_t got;
    if (!rst) begin
      if (start && !busy)
        pending_dates.push_back(drive_typed ? drive_date : to_calendar(unix_seconds));
      if (done) begin
        got = {second, minute, hour, weekday, years_since_1900, day_of_year,
               month_index, day_of_month};
        if (pending_dates.size() == 0) begin
          $error("done with no word outstanding");
          mismatch_count++;
        end else begin
          compare_date(pending_dates.pop_front(), got);
        end
      end
    end
  end

  // Offer one word after an idle gap; returns on the accepting edge.
  // With no gap, start stays high and only the data moves.
  task automatic send_word(input logic [31:0] secs, input logic typed, input cal_date_t date,
                           input int gap);
    if (gap > 0) begin
      @(negedge clk);
      start        <= 1'b0;
      unix_seconds <= $urandom;   // junk while idle
      drive_typed  <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start        <= 1'b1;
    unix_seconds <= secs;
    drive_typed  <= typed;
    drive_date   <= date;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Stop offering and let every outstanding word come back.
  task automatic drain_pipe;
    @(negedge clk);
    start       <= 1'b0;
    drive_typed <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
  endtask

  // Per-word gap, by the idling style of the current stretch:
  // none, uniform 0..19, or mostly back-to-back with the odd gap.
  function automatic int draw_gap(input int style);
    if (style == 0)
      return 0;
    if (style == 1)
      return $urandom_range(0, 19);
    return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
  endfunction

  // Random word, biased toward places where the calendar logic turns over.
  function automatic logic [31:0] draw_seconds;
    longint unsigned v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = 64'($urandom);
      // a couple of seconds either side of midnight
      5, 6: begin
        v = longint'($urandom_range(1, LAST_UNIX_DAY)) * SECS_PER_DAY;
        v = v - 2 + $urandom_range(0, 4);
      end
      // the top end: late December 2098 through 2106, with the fake leap day of 2100
      7: v = 64'($urandom_range(32'hF2A3_0000, 32'hFFFF_FFFF));
      // first years after 1970
      8: v = 64'($urandom_range(0, 32'h0400_0000));
      default: begin
        // late February / early March of a random year, drifting earlier in later years
        v = longint'($urandom_range(0, 135)) * 365 * SECS_PER_DAY
            + longint'($urandom_range(50, 70)) * SECS_PER_DAY + $urandom_range(0, 86399);
      end
    endcase
    if (v > 64'hFFFF_FFFF)
      v = 64'hFFFF_FFFF;
    return v[31:0];
  endfunction

  initial begin : stimulus
    int style;
    rst            = 1'b1;
    start          = 1'b0;
    unix_seconds   = '0;
    drive_typed    = 1'b0;
    drive_date     = '0;
    mismatch_count = 0;

    // Directed words. Typed rows: epoch, end of the first minute and day,
    // first second of day two, and the last representable second.
    dir_rows[0]  = '{32'd0,          1'b1, '{6'd0,  6'd0,  5'd0,  3'd4, 8'd70,  9'd0,  4'd0, 5'd1}};
    dir_rows[1]  = '{32'd59,         1'b1, '{6'd59, 6'd0,  5'd0,  3'd4, 8'd70,  9'd0,  4'd0, 5'd1}};
    dir_rows[2]  = '{32'd86399,      1'b1, '{6'd59, 6'd59, 5'd23, 3'd4, 8'd70,  9'd0,  4'd0, 5'd1}};
    dir_rows[3]  = '{32'd86400,      1'b1, '{6'd0,  6'd0,  5'd0,  3'd5, 8'd70,  9'd1,  4'd0, 5'd2}};
    dir_rows[4]  = '{32'd31449600,   1'b0, '0};   // 1970-12-31, last day of a common year
    dir_rows[5]  = '{32'd31536000,   1'b0, '0};   // 1971-01-01
    dir_rows[6]  = '{32'd36633600,   1'b0, '0};   // 1971-03-01, common-year shift
    dir_rows[7]  = '{32'd68169600,   1'b0, '0};   // 1972-02-29
    dir_rows[8]  = '{32'd68255999,   1'b0, '0};   // last second of it
    dir_rows[9]  = '{32'd951782400,  1'b0, '0};   // 2000-02-29
    dir_rows[10] = '{32'd1735603200, 1'b0, '0};   // 2024-12-31, yday 365
    dir_rows[11] = '{32'h7FFF_FFFF,  1'b0, '0};
    dir_rows[12] = '{32'h8000_0000,  1'b0, '0};
    dir_rows[13] = '{32'd4107542399, 1'b0, '0};   // 2100 as leap: 28 Feb ends
    dir_rows[14] = '{32'd4107542400, 1'b0, '0};   // ... and 29 Feb 2100 exists
    dir_rows[15] = '{32'd4107628800, 1'b0, '0};
    dir_rows[16] = '{32'hAAAA_AAAA,  1'b0, '0};
    dir_rows[17] = '{32'h5555_5555,  1'b0, '0};
    dir_rows[18] = '{32'hFFFF_0000,  1'b0, '0};
    dir_rows[19] = '{32'hFFFF_FFFE,  1'b0, '0};
    dir_rows[20] = '{32'hFFFF_FFFF,  1'b1, '{6'd15, 6'd28, 5'd6, 3'd0, 8'd206, 9'd36, 4'd1, 5'd6}};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_DIR; i++)
      send_word(dir_rows[i].secs, dir_rows[i].typed, dir_rows[i].date, draw_gap(2));
    // hold off until the pipe is empty once
    drain_pipe();

    style = 1;
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i % 64 == 0)
        style = $urandom_range(0, 2);
      if (i == NUM_RANDOM / 2)
        drain_pipe();
      send_word(draw_seconds(), 1'b0, '0, draw_gap(style));
    end

    @(negedge clk);
    start       <= 1'b0;
    drive_typed <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    // catch any stray strobe after the last expected word
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // Watchdog: worst case is ~1.6k words, each after its longest idle gap, plus the drains.
  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

endmodule
